// ----- design/fmsc_pkg.sv -----
// Shared types and constants for the FFT magnitude spectrum core.
// Used by the front queue, the back engine and the top level.
`default_nettype none

package fmsc_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BIN_W    = 9;
  localparam int unsigned MAG_W    = 26;
  localparam int unsigned QDEPTH   = 2;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
    logic [BIN_W-1:0]    bin;
  } fmsc_item_t;

  typedef struct packed {
    logic       valid;
    fmsc_item_t item;
  } fmsc_req_t;

endpackage

`default_nettype wire

// ----- design/fft_magnitude_spectrum_core.sv -----
// Top level of the FFT magnitude spectrum core: stream ports, front queue, back engine.
// Depends on fmsc_pkg, fmsc_front and fmsc_back.
//
// A push transfer (tuser 0) takes one real sample; samples land in bit-reversed
// order, so the push that completes a frame starts the radix-2 transform at once.
// The transform runs on one shared butterfly over the frame memory. A read
// transfer (tuser 1) returns the integer magnitude of bin (bin mod POINTS/2)
// through the one-bit-per-cycle square root; while no transformed frame is held
// it returns zero with frame_ready low. A two-entry input queue and an output
// register decouple both stream sides.
`default_nettype none

module fft_magnitude_spectrum_core #(
  parameter int unsigned POINTS       = 1024,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned TWIDDLE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // sample [15:0], bin [24:16], zero [31:25]
  input  wire logic        s_axis_tuser,   // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // magnitude [25:0], zero [31:26]
  output logic             m_axis_tuser    // frame_ready
);

  fmsc_pkg::fmsc_item_t in_item;
  fmsc_pkg::fmsc_req_t  req;
  logic                 req_ready;
  logic [fmsc_pkg::MAG_W-1:0] mag;

  assign in_item.op     = s_axis_tuser;
  assign in_item.sample = s_axis_tdata[15:0];
  assign in_item.bin    = s_axis_tdata[24:16];

  fmsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  fmsc_back #(
    .POINTS       (POINTS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_i             (req),
    .req_ready_o       (req_ready),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_mag_o         (mag),
    .out_frame_ready_o (m_axis_tuser)
  );

  assign m_axis_tdata = {{(32 - fmsc_pkg::MAG_W){1'b0}}, mag};

endmodule

`default_nettype wire

// ----- design/fmsc_front.sv -----
// Front end: accepts input transfers and holds them in a short queue.
// Depends on fmsc_pkg for the item and request types.
`default_nettype none

module fmsc_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire fmsc_pkg::fmsc_item_t   in_item_i,
  output fmsc_pkg::fmsc_req_t         req_o,
  input  wire logic                   req_ready_i
);

  localparam int unsigned PW = $clog2(fmsc_pkg::QDEPTH);

  fmsc_pkg::fmsc_item_t slot_q [fmsc_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PW:0]   count_q, count_d;
  logic          push, pop;

  assign in_ready_o  = (count_q != (PW+1)'(fmsc_pkg::QDEPTH));
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_o.valid && req_ready_i;
  assign req_o.valid = (count_q != '0);
  assign req_o.item  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/fmsc_isqrt.sv -----
// Iterative 64-bit integer square root, one result bit per cycle.
// Standalone unit used by the back engine; no package dependency.
`default_nettype none

module fmsc_isqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] value_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic [63:0] v_q, v_d, res_q, res_d, bit_q, bit_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [63:0] trial;

  assign trial  = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[31:0];

  always_comb begin
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = value_i;
      res_d  = '0;
      bit_d  = 64'h4000_0000_0000_0000;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
    cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/fmsc_back.sv -----
// Back engine: frame store, twiddle ROM, butterfly sequencer and magnitude path.
// Depends on fmsc_pkg and fmsc_isqrt.
`default_nettype none

module fmsc_back #(
  parameter int unsigned POINTS       = 1024,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned TWIDDLE_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire fmsc_pkg::fmsc_req_t       req_i,
  output logic                           req_ready_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [fmsc_pkg::MAG_W-1:0]     out_mag_o,
  output logic                           out_frame_ready_o
);

  localparam int unsigned LOG  = $clog2(POINTS);
  localparam int unsigned HALF = POINTS / 2;
  localparam int unsigned HW   = LOG - 1;
  localparam int unsigned SW   = $clog2(LOG);
  localparam int unsigned TW   = TWIDDLE_BITS;
  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned PW   = TW + 32;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef logic [2*TW-1:0] tw_rom_t [HALF];

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] taylor(input logic [63:0] x, input logic want_sin);
    logic [63:0] x2, term, n;
    logic signed [63:0] acc;
    logic neg;
    x2   = (x * x) >> 30;
    term = want_sin ? x : ONE_Q30;
    n    = want_sin ? 64'd2 : 64'd1;
    acc  = '0;
    neg  = 1'b0;
    for (int i = 0; i < 14; i++) begin
      if (term != 0) begin
        acc  = neg ? acc - $signed(term) : acc + $signed(term);
        term = udiv((term * x2) >> 30, n * (n + 64'd1));
        n    = n + 64'd2;
        neg  = !neg;
      end
    end
    return acc;
  endfunction

  function automatic logic [TW-1:0] to_tw(input logic signed [63:0] v);
    logic [63:0] m, lim;
    logic neg;
    neg = v < 0;
    m   = neg ? 64'(-v) : 64'(v);
    lim = (64'd1 << (TW - 1)) - 64'd1;
    m   = (m + (64'd1 << (30 - TW))) >> (31 - TW);
    if (m > lim) begin
      m = lim;
    end
    return neg ? TW'(-m) : TW'(m);
  endfunction

  function automatic tw_rom_t build_tw();
    tw_rom_t rom;
    logic [63:0] num, den, x;
    logic signed [63:0] c, s;
    for (int k = 0; k < HALF; k++) begin
      if (4 * k <= POINTS) begin
        num = 64'(k);
        den = 64'(POINTS);
      end else begin
        num = 64'(4 * k - POINTS);
        den = 64'(4 * POINTS);
      end
      x = udiv(64'd2 * PI_Q30 * num + (den >> 1), den);
      if (x > (PI_Q30 >> 1)) begin
        x = PI_Q30 >> 1;
      end
      if (4 * k <= POINTS) begin
        c = taylor(x, 1'b0);
        s = taylor(x, 1'b1);
      end else begin
        c = -taylor(x, 1'b1);
        s = taylor(x, 1'b0);
      end
      rom[k] = {to_tw(s), to_tw(c)};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_tw();

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_BF_RA   = 4'd1;
  localparam logic [3:0] S_BF_RB   = 4'd2;
  localparam logic [3:0] S_BF_MUL  = 4'd3;
  localparam logic [3:0] S_BF_ADD  = 4'd4;
  localparam logic [3:0] S_BF_WA   = 4'd5;
  localparam logic [3:0] S_BF_WB   = 4'd6;
  localparam logic [3:0] S_RD_MEM  = 4'd7;
  localparam logic [3:0] S_RD_SQ   = 4'd8;
  localparam logic [3:0] S_RD_SUM  = 4'd9;
  localparam logic [3:0] S_RD_SQRT = 4'd10;
  localparam logic [3:0] S_RD_OUT  = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [LOG-1:0] load_q, load_d;
  logic          done_q, done_d;
  logic [SW-1:0] stm1_q, stm1_d;
  logic [HW-1:0] j_q, j_d;
  logic [HW-1:0] bin_q, bin_d;

  logic [63:0] mem [POINTS];
  logic [63:0] rdata_q;
  logic [LOG-1:0] raddr, waddr;
  logic [63:0] wdata;
  logic        we;

  logic [2*TW-1:0] tw_q;
  logic signed [31:0] ar_q, ai_q, tr_q, ti_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [PW:0]   sr, si;
  logic signed [TW-1:0] wc, ws;
  logic signed [31:0] br, bi, rre, rim;
  logic [63:0] sq1_q, sq2_q;

  logic        out_valid_q, out_valid_d, out_fr_q, out_fr_d;
  logic [fmsc_pkg::MAG_W-1:0] out_mag_q, out_mag_d;
  logic        out_free;

  logic        sq_start, sq_done;
  logic [31:0] sq_root;

  logic [LOG-1:0] jx, half, a_addr, b_addr, rev_load;
  logic [HW-1:0]  tw_idx;
  logic [SB-1:0]  smp;
  logic [31:0]    smp_ext;
  logic [HW-1:0]  bin_lo;
  logic           last_bf;

  always_comb begin
    for (int i = 0; i < SB; i++) begin
      smp[i] = (i < fmsc_pkg::SAMPLE_W) ? req_i.item.sample[i] : 1'b0;
    end
    for (int i = 0; i < HW; i++) begin
      bin_lo[i] = (i < fmsc_pkg::BIN_W) ? req_i.item.bin[i] : 1'b0;
    end
    for (int i = 0; i < LOG; i++) begin
      rev_load[i] = load_q[LOG-1-i];
    end
  end
  assign smp_ext = {{(32-SB){smp[SB-1]}}, smp};

  assign jx      = {1'b0, j_q};
  assign half    = LOG'(1) << stm1_q;
  assign a_addr  = ((jx >> stm1_q) << (stm1_q + SW'(1))) | (jx & (half - LOG'(1)));
  assign b_addr  = a_addr | half;
  assign tw_idx  = HW'((jx & (half - LOG'(1))) << (SW'(HW) - stm1_q));
  assign last_bf = (j_q == {HW{1'b1}}) && (stm1_q == SW'(LOG - 1));

  assign wc  = tw_q[TW-1:0];
  assign ws  = tw_q[2*TW-1:TW];
  assign br  = rdata_q[31:0];
  assign bi  = rdata_q[63:32];
  assign rre = rdata_q[31:0];
  assign rim = rdata_q[63:32];
  assign sr  = (PW+1)'(p1_q) + (PW+1)'(p2_q) + ((PW+1)'(1) << (TW - 2));
  assign si  = (PW+1)'(p3_q) - (PW+1)'(p4_q) + ((PW+1)'(1) << (TW - 2));

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    load_d      = load_q;
    done_d      = done_q;
    stm1_d      = stm1_q;
    j_d         = j_q;
    bin_d       = bin_q;
    req_ready_o = 1'b0;
    raddr       = a_addr;
    waddr       = a_addr;
    wdata       = {ai_q + ti_q, ar_q + tr_q};
    we          = 1'b0;
    sq_start    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_mag_d   = out_mag_q;
    out_fr_d    = out_fr_q;
    unique case (state_q)
      S_IDLE: begin
        raddr = LOG'(bin_q);
        if (req_i.valid) begin
          if (req_i.item.op == fmsc_pkg::OP_PUSH) begin
            req_ready_o = 1'b1;
            we          = 1'b1;
            waddr       = rev_load;
            wdata       = {32'd0, smp_ext};
            done_d      = 1'b0;
            load_d      = load_q + LOG'(1);
            if (load_q == {LOG{1'b1}}) begin
              stm1_d  = '0;
              j_d     = '0;
              state_d = S_BF_RA;
            end
          end else if (done_q) begin
            req_ready_o = 1'b1;
            bin_d       = bin_lo;
            state_d     = S_RD_MEM;
          end else if (out_free) begin
            req_ready_o = 1'b1;
            out_valid_d = 1'b1;
            out_mag_d   = '0;
            out_fr_d    = 1'b0;
          end
        end
      end
      S_BF_RA: begin
        raddr   = a_addr;
        state_d = S_BF_RB;
      end
      S_BF_RB: begin
        raddr   = b_addr;
        state_d = S_BF_MUL;
      end
      S_BF_MUL: state_d = S_BF_ADD;
      S_BF_ADD: state_d = S_BF_WA;
      S_BF_WA: begin
        we      = 1'b1;
        waddr   = a_addr;
        wdata   = {ai_q + ti_q, ar_q + tr_q};
        state_d = S_BF_WB;
      end
      S_BF_WB: begin
        we    = 1'b1;
        waddr = b_addr;
        wdata = {ai_q - ti_q, ar_q - tr_q};
        j_d   = j_q + HW'(1);
        if (j_q == {HW{1'b1}}) begin
          stm1_d = stm1_q + SW'(1);
        end
        if (last_bf) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_BF_RA;
        end
      end
      S_RD_MEM: begin
        raddr   = LOG'(bin_q);
        state_d = S_RD_SQ;
      end
      S_RD_SQ: state_d = S_RD_SUM;
      S_RD_SUM: begin
        sq_start = 1'b1;
        state_d  = S_RD_SQRT;
      end
      S_RD_SQRT: begin
        if (sq_done) begin
          state_d = S_RD_OUT;
        end
      end
      S_RD_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_mag_d   = (sq_root > 32'(fmsc_pkg::MAG_MAX)) ? fmsc_pkg::MAG_MAX
                                                           : sq_root[fmsc_pkg::MAG_W-1:0];
          out_fr_d    = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
    tw_q    <= TW_ROM[tw_idx];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_BF_RB) begin
      ar_q <= rdata_q[31:0];
      ai_q <= rdata_q[63:32];
    end
    if (state_q == S_BF_MUL) begin
      p1_q <= wc * br;
      p2_q <= ws * bi;
      p3_q <= wc * bi;
      p4_q <= ws * br;
    end
    if (state_q == S_BF_ADD) begin
      tr_q <= sr[TW-1 +: 32];
      ti_q <= si[TW-1 +: 32];
    end
    if (state_q == S_RD_SQ) begin
      sq1_q <= 64'(rre * rre);
      sq2_q <= 64'(rim * rim);
    end
    out_mag_q <= out_mag_d;
    out_fr_q  <= out_fr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_q      <= '0;
      done_q      <= 1'b0;
      stm1_q      <= '0;
      j_q         <= '0;
      bin_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_q      <= load_d;
      done_q      <= done_d;
      stm1_q      <= stm1_d;
      j_q         <= j_d;
      bin_q       <= bin_d;
      out_valid_q <= out_valid_d;
    end
  end

  fmsc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq1_q + sq2_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign out_valid_o       = out_valid_q;
  assign out_mag_o         = out_mag_q;
  assign out_frame_ready_o = out_fr_q;

endmodule

`default_nettype wire
